### design/smma_pkg.sv
// ----------------------------------------------------------------------------
// smma_pkg
// Shared types and constants for the sparse matrix merge-add block.
// ----------------------------------------------------------------------------
package smma_pkg;

  // default sizes
  localparam int unsigned MAX_TERMS_DEF  = 16;
  localparam int unsigned INDEX_BITS_DEF = 8;

  // field widths on the ports
  localparam int unsigned OP_W   = 2;
  localparam int unsigned ROW_W  = 8;
  localparam int unsigned VAL_W  = 16;
  localparam int unsigned SUM_W  = 17;
  localparam int unsigned S_DATA_W = 32;
  localparam int unsigned S_USER_W = 2;
  localparam int unsigned M_DATA_W = 40;
  localparam int unsigned M_USER_W = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_APPEND_A = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND_B = 2'd1;
  localparam logic [OP_W-1:0] OP_MERGE    = 2'd2;

  // decision of one merge step
  typedef struct packed {
    logic                    take_a;
    logic                    take_b;
    logic [ROW_W-1:0]        row;
    logic [ROW_W-1:0]        col;
    logic signed [SUM_W-1:0] sum;
  } pick_t;

endpackage

### design/smma_pick.sv
// ----------------------------------------------------------------------------
// smma_pick
// Compare/add unit for one merge step: orders the heads of both lists by
// row then column, adds on a coordinate match, else passes the lower term.
// ----------------------------------------------------------------------------
module smma_pick #(
  parameter int unsigned IW = 8
) (
  input  logic                           a_has_i,
  input  logic                           b_has_i,
  input  logic [IW-1:0]                  a_row_i,
  input  logic [IW-1:0]                  a_col_i,
  input  logic signed [smma_pkg::VAL_W-1:0] a_val_i,
  input  logic [IW-1:0]                  b_row_i,
  input  logic [IW-1:0]                  b_col_i,
  input  logic signed [smma_pkg::VAL_W-1:0] b_val_i,
  output smma_pkg::pick_t                pick_o
);
  import smma_pkg::*;

  logic                    same;
  logic                    a_gt;
  logic signed [SUM_W-1:0] a_ext;
  logic signed [SUM_W-1:0] b_ext;

  // coordinate compare and widened sum
  assign same  = (a_row_i == b_row_i) && (a_col_i == b_col_i);
  assign a_gt  = (a_row_i > b_row_i) || ((a_row_i == b_row_i) && (a_col_i > b_col_i));
  assign a_ext = SUM_W'(a_val_i);
  assign b_ext = SUM_W'(b_val_i);

  // choose which head goes out
  always_comb begin
    pick_o.take_a = 1'b0;
    pick_o.take_b = 1'b0;
    pick_o.row    = ROW_W'(a_row_i);
    pick_o.col    = ROW_W'(a_col_i);
    pick_o.sum    = a_ext;
    if (a_has_i && b_has_i) begin
      if (same) begin
        pick_o.take_a = 1'b1;
        pick_o.take_b = 1'b1;
        pick_o.sum    = a_ext + b_ext;
      end else if (a_gt) begin
        pick_o.take_b = 1'b1;
        pick_o.row    = ROW_W'(b_row_i);
        pick_o.col    = ROW_W'(b_col_i);
        pick_o.sum    = b_ext;
      end else begin
        pick_o.take_a = 1'b1;
      end
    end else if (a_has_i) begin
      pick_o.take_a = 1'b1;
    end else if (b_has_i) begin
      pick_o.take_b = 1'b1;
      pick_o.row    = ROW_W'(b_row_i);
      pick_o.col    = ROW_W'(b_col_i);
      pick_o.sum    = b_ext;
    end
  end

endmodule

### design/sparse_matrix_merge_add.sv
// ----------------------------------------------------------------------------
// sparse_matrix_merge_add
// Adds two sparse matrices kept as row-major (row, col, value) lists by a
// merge walk over both lists.
//
//   channel | dir | tdata (low bit up)              | tuser / tlast
//   s_axis  | in  | term_row, term_col, term_value  | tuser: op
//   m_axis  | out | out_row, out_col, out_sum       | tuser: no_terms, overflowed;
//           |     |                                 | tlast: last_term
//
// Append transactions are taken while idle; op code 3 is dropped silently.
// A merge walks both lists through the shared compare/add unit, one result
// term per cycle while m_axis accepts.
// Stalls on m_axis hold the walk; s_axis is not ready during a merge.
// Reset clears both counts and the overflow flag; list storage is not reset.
// ----------------------------------------------------------------------------
module sparse_matrix_merge_add #(
  parameter int unsigned MAX_TERMS  = smma_pkg::MAX_TERMS_DEF,
  parameter int unsigned INDEX_BITS = smma_pkg::INDEX_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [smma_pkg::S_DATA_W-1:0] s_axis_tdata,  // term_row, term_col, term_value
  input  logic [smma_pkg::S_USER_W-1:0] s_axis_tuser,  // op
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [smma_pkg::M_DATA_W-1:0] m_axis_tdata,  // out_row, out_col, out_sum, pad
  output logic [smma_pkg::M_USER_W-1:0] m_axis_tuser,  // no_terms, overflowed
  output logic                          m_axis_tlast
);
  import smma_pkg::*;

  localparam int unsigned IW = (INDEX_BITS < ROW_W) ? INDEX_BITS : ROW_W;
  localparam int unsigned CW = $clog2(MAX_TERMS + 1);
  localparam int unsigned AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int unsigned TW = 2 * IW + VAL_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MERGE = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d;
  logic          drop_q, drop_d;

  logic [TW-1:0] mem_a_q [MAX_TERMS];
  logic [TW-1:0] mem_b_q [MAX_TERMS];

  logic                    out_vld_q, out_vld_d;
  logic [ROW_W-1:0]        out_row_q, out_row_d, out_col_q, out_col_d;
  logic signed [SUM_W-1:0] out_sum_q, out_sum_d;
  logic                    out_last_q, out_last_d;
  logic                    out_none_q, out_none_d;
  logic                    out_ovf_q, out_ovf_d;

  logic          s_fire, out_free;
  logic [OP_W-1:0] op;
  logic [TW-1:0] in_term;
  logic          wr_a, wr_b;
  logic [TW-1:0] head_a_q, head_b_q;
  logic          a_has, b_has;
  logic [CW-1:0] i_nxt, j_nxt;
  pick_t         pick;

  // input decode
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire   = s_axis_tvalid && s_axis_tready;
  assign op       = s_axis_tuser;
  assign in_term  = {s_axis_tdata[31:16], s_axis_tdata[8 +: IW], s_axis_tdata[0 +: IW]};
  assign wr_a     = s_fire && (op == OP_APPEND_A) && (cnt_a_q < CW'(MAX_TERMS));
  assign wr_b     = s_fire && (op == OP_APPEND_B) && (cnt_b_q < CW'(MAX_TERMS));
  assign out_free = !out_vld_q || m_axis_tready;

  // list storage, heads read at the next walk position
  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      mem_a_q[cnt_a_q[AW-1:0]] <= in_term;
    end
    if (wr_b) begin
      mem_b_q[cnt_b_q[AW-1:0]] <= in_term;
    end
    head_a_q <= mem_a_q[i_d[AW-1:0]];
    head_b_q <= mem_b_q[j_d[AW-1:0]];
  end

  // list heads into the compare/add unit
  assign a_has  = i_q < cnt_a_q;
  assign b_has  = j_q < cnt_b_q;

  smma_pick #(
    .IW (IW)
  ) u_pick (
    .a_has_i (a_has),
    .b_has_i (b_has),
    .a_row_i (head_a_q[IW-1:0]),
    .a_col_i (head_a_q[2*IW-1:IW]),
    .a_val_i (head_a_q[TW-1:2*IW]),
    .b_row_i (head_b_q[IW-1:0]),
    .b_col_i (head_b_q[2*IW-1:IW]),
    .b_val_i (head_b_q[TW-1:2*IW]),
    .pick_o  (pick)
  );

  assign i_nxt = i_q + CW'(pick.take_a);
  assign j_nxt = j_q + CW'(pick.take_b);

  // sequencer
  always_comb begin
    state_d    = state_q;
    cnt_a_d    = cnt_a_q;
    cnt_b_d    = cnt_b_q;
    i_d        = i_q;
    j_d        = j_q;
    drop_d     = drop_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_row_d  = out_row_q;
    out_col_d  = out_col_q;
    out_sum_d  = out_sum_q;
    out_last_d = out_last_q;
    out_none_d = out_none_q;
    out_ovf_d  = out_ovf_q;
    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          case (op)
            OP_APPEND_A: begin
              if (wr_a) cnt_a_d = cnt_a_q + CW'(1);
              else      drop_d  = 1'b1;
            end
            OP_APPEND_B: begin
              if (wr_b) cnt_b_d = cnt_b_q + CW'(1);
              else      drop_d  = 1'b1;
            end
            OP_MERGE: begin
              i_d = '0;
              j_d = '0;
              if (cnt_a_q == '0 && cnt_b_q == '0) state_d = ST_EMPTY;
              else                                state_d = ST_MERGE;
            end
            default: ;
          endcase
        end
      end
      ST_MERGE: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_row_d  = pick.row;
          out_col_d  = pick.col;
          out_sum_d  = pick.sum;
          out_none_d = 1'b0;
          out_ovf_d  = drop_q;
          out_last_d = (i_nxt >= cnt_a_q) && (j_nxt >= cnt_b_q);
          i_d        = i_nxt;
          j_d        = j_nxt;
          if (out_last_d) begin
            cnt_a_d = '0;
            cnt_b_d = '0;
            drop_d  = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_row_d  = '0;
          out_col_d  = '0;
          out_sum_d  = '0;
          out_none_d = 1'b1;
          out_last_d = 1'b1;
          out_ovf_d  = drop_q;
          drop_d     = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_a_q   <= '0;
      cnt_b_q   <= '0;
      i_q       <= '0;
      j_q       <= '0;
      drop_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_a_q   <= cnt_a_d;
      cnt_b_q   <= cnt_b_d;
      i_q       <= i_d;
      j_q       <= j_d;
      drop_q    <= drop_d;
      out_vld_q <= out_vld_d;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    out_row_q  <= out_row_d;
    out_col_q  <= out_col_d;
    out_sum_q  <= out_sum_d;
    out_last_q <= out_last_d;
    out_none_q <= out_none_d;
    out_ovf_q  <= out_ovf_d;
  end

  // output port packing
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_sum_q, out_col_q, out_row_q};
  assign m_axis_tuser  = {out_ovf_q, out_none_q};
  assign m_axis_tlast  = out_last_q;

endmodule
